>>> sv/ncas_pkg.sv
// ----------------------------------------------------------------------------
// ncas_pkg: shared types and constants of the nearest-centroid assigner
// Field widths, stream packing, register indexes, command codes, the
// sequencer state type and the control bundle of the squaring unit.
// ----------------------------------------------------------------------------
package ncas_pkg;

    // Widths of the stream fields
    localparam int CMD_W      = 1;
    localparam int CSEL_W     = 4;
    localparam int DSEL_W     = 6;
    localparam int CARRIER_W  = 16;
    localparam int LABEL_W    = 4;
    localparam int SUM_W      = 38;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    // Arithmetic widths: extended coordinate, difference, magnitude, square
    localparam int VAL_W      = CARRIER_W + 1;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int MAG_W      = VAL_W;
    localparam int SQ_W       = 2 * MAG_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int NCREG_W    = 5;
    localparam int DIMREG_W   = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CENTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS        = 2'd1;

    // Item kinds carried on tuser
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POINT = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } ncas_state_t;

    // Control of the squaring stage
    typedef struct packed {
        logic en;      // a center operand pair is present this cycle
        logic update;  // the coordinate lies within dims and adds its square
    } ncas_sq_ctl_t;

endpackage

>>> sv/ncas_center_store.sv
// ----------------------------------------------------------------------------
// ncas_center_store: center coordinate memory
// One write port for center loads and one registered read port that the
// sequencer sweeps over the centers of the current coordinate.
// ----------------------------------------------------------------------------
module ncas_center_store #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ncas_sum_bank.sv
// ----------------------------------------------------------------------------
// ncas_sum_bank: per-center running distance sums
// A small memory with one valid bit per center. An entry that is not
// valid reads as zero, so dropping all valid bits clears every sum at
// the end of a point.
// ----------------------------------------------------------------------------
module ncas_sum_bank
    import ncas_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [SUM_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [SUM_W-1:0]  rd_data
);

    logic [SUM_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [SUM_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    // Valid bits: set on write, all dropped on reset or clear
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Sum storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read with its valid bit
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> sv/ncas_sq_unit.sv
// ----------------------------------------------------------------------------
// ncas_sq_unit: shared squared-difference accumulator
// Extends the point and center coordinates, squares their difference into
// a register, then adds the square to the running sum with saturation.
// ----------------------------------------------------------------------------
module ncas_sq_unit
    import ncas_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int STORE_W    = 16
) (
    input  logic               aclk,
    input  ncas_sq_ctl_t       ctl,
    input  logic [STORE_W-1:0] point_raw,
    input  logic [STORE_W-1:0] center_raw,
    input  logic [SUM_W-1:0]   acc_in,
    output logic [SUM_W-1:0]   sum_out
);

    logic signed [VAL_W-1:0]  p_ext;
    logic signed [VAL_W-1:0]  c_ext;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]         mag;
    logic [SQ_W-1:0]          sq;
    logic [SQ_W-1:0]          sq_reg;
    logic [SUM_W-1:0]         acc_reg;
    logic [SUM_W:0]           sum_wide;

    // Coordinates no wider than the carrier are signed; wider ones see only
    // the carrier bits, whose top bit is then never the sign.
    always_comb begin
        if (COORD_BITS <= CARRIER_W) begin
            p_ext = VAL_W'($signed(point_raw));
            c_ext = VAL_W'($signed(center_raw));
        end else begin
            p_ext = $signed(VAL_W'(point_raw));
            c_ext = $signed(VAL_W'(center_raw));
        end
    end

    // Difference, magnitude and square
    assign diff = DIFF_W'(p_ext) - DIFF_W'(c_ext);
    assign mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign sq   = mag * mag;

    // Square stage register
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            sq_reg  <= ctl.update ? sq : '0;
            acc_reg <= acc_in;
        end
    end

    // Saturating accumulate
    assign sum_wide = {1'b0, acc_reg} + (SUM_W + 1)'(sq_reg);
    assign sum_out  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

endmodule

>>> sv/nearest_centroid_assign_top.sv
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top: k-means nearest-center assignment
// Loads center coordinates, accumulates squared distances of streamed point
// coordinates to every active center and reports the nearest center.
// ----------------------------------------------------------------------------
// A center load goes straight into the store and leaves the block ready
// for the next item. A point coordinate is accepted, then passed one
// active center after another through the single shared squaring and
// accumulate unit, after which the registered memory read and the square
// stage drain. The coordinate flagged last then passes through S_DONE,
// which moves the result into the output register only once an earlier
// result has been taken or none is pending. A new input is not accepted
// while a point coordinate is in progress. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top
    import ncas_pkg::*;
#(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_DIMS    = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // center_sel[3:0], dim_sel[9:4], coord_value[25:10]
    input  logic [CMD_W-1:0]      s_tuser,  // cmd[0]
    input  logic                  s_tlast,  // coord_last
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // label[3:0], min_distance[41:4]
    output logic                  m_tuser   // count_mismatch[0]
);

    localparam int CW      = $clog2(MAX_CENTERS);
    localparam int KW      = $clog2(MAX_CENTERS + 1);
    localparam int DIW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DCW     = $clog2(MAX_DIMS + 2);
    localparam int STORE_W = (COORD_BITS < CARRIER_W) ? COORD_BITS : CARRIER_W;
    localparam int ST_AW   = CW + DIW;

    // Input fields
    logic [CSEL_W-1:0]    in_csel;
    logic [DSEL_W-1:0]    in_dsel;
    logic [CARRIER_W-1:0] in_coord;
    logic                 s_acc;

    assign in_csel  = s_tdata[CSEL_W-1:0];
    assign in_dsel  = s_tdata[CSEL_W +: DSEL_W];
    assign in_coord = s_tdata[CSEL_W + DSEL_W +: CARRIER_W];
    assign s_acc    = s_tvalid && s_tready;

    // Registers
    ncas_state_t         state_reg, state_next;
    logic [NCREG_W-1:0]  num_centers_reg;
    logic [DIMREG_W-1:0] dims_reg;
    logic [DCW-1:0]      coord_count_reg, coord_count_next;
    logic [CW-1:0]       iss_reg, iss_next;
    logic                p1_v_reg, p1_v_next;
    logic [CW-1:0]       p1_c_reg, p1_c_next;
    logic                p2_v_reg, p2_v_next;
    logic [CW-1:0]       p2_c_reg, p2_c_next;
    logic [STORE_W-1:0]  x_reg, x_next;
    logic                upd_reg, upd_next;
    logic                last_reg, last_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [DIW-1:0]      dim_reg, dim_next;
    logic                mismatch_reg, mismatch_next;
    logic [SUM_W-1:0]    best_sum_reg, best_sum_next;
    logic [CW-1:0]       best_c_reg, best_c_next;
    logic                m_valid_reg, m_valid_next;
    logic [LABEL_W-1:0]  m_label_reg, m_label_next;
    logic [SUM_W-1:0]    m_dist_reg, m_dist_next;
    logic                m_mis_reg, m_mis_next;

    // Datapath wires
    logic [KW-1:0]      k_eff;
    logic [DCW-1:0]     d_eff;
    logic [DCW-1:0]     cnt_inc;
    logic               st_we;
    logic [STORE_W-1:0] center_rd;
    logic [SUM_W-1:0]   acc_rd;
    logic [SUM_W-1:0]   sum_new;
    logic               sum_clr;
    ncas_sq_ctl_t       sq_ctl;

    // Effective register values, clamped to the supported range
    always_comb begin
        if (num_centers_reg == '0) begin
            k_eff = KW'(1);
        end else if (32'(num_centers_reg) > MAX_CENTERS) begin
            k_eff = KW'(MAX_CENTERS);
        end else begin
            k_eff = KW'(num_centers_reg);
        end
        if (dims_reg == '0) begin
            d_eff = DCW'(1);
        end else if (32'(dims_reg) > MAX_DIMS) begin
            d_eff = DCW'(MAX_DIMS);
        end else begin
            d_eff = DCW'(dims_reg);
        end
    end

    // Coordinate count saturates one above the largest dims
    assign cnt_inc = (32'(coord_count_reg) < MAX_DIMS + 1) ?
                     coord_count_reg + DCW'(1) : coord_count_reg;

    // Center loads go straight to the store
    assign st_we = s_acc && (s_tuser == CMD_LOAD) &&
                   (32'(in_csel) < MAX_CENTERS) && (32'(in_dsel) < MAX_DIMS);

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_centers_reg <= NCREG_W'(16);
            dims_reg        <= DIMREG_W'(64);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NUM_CENTERS: num_centers_reg <= cfg_data[NCREG_W-1:0];
                CFG_DIMS:        dims_reg        <= cfg_data[DIMREG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and result tracking
    always_comb begin
        state_next       = state_reg;
        coord_count_next = coord_count_reg;
        iss_next         = iss_reg;
        p1_v_next        = 1'b0;
        p1_c_next        = iss_reg;
        p2_v_next        = p1_v_reg;
        p2_c_next        = p1_c_reg;
        x_next           = x_reg;
        upd_next         = upd_reg;
        last_next        = last_reg;
        k_next           = k_reg;
        dim_next         = dim_reg;
        mismatch_next    = mismatch_reg;
        best_sum_next    = best_sum_reg;
        best_c_next      = best_c_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_label_next     = m_label_reg;
        m_dist_next      = m_dist_reg;
        m_mis_next       = m_mis_reg;
        sum_clr          = 1'b0;

        // Running minimum over the sums as they are written back
        if (p2_v_reg && ((p2_c_reg == '0) || (sum_new < best_sum_reg))) begin
            best_sum_next = sum_new;
            best_c_next   = p2_c_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && (s_tuser == CMD_POINT)) begin
                    x_next           = in_coord[STORE_W-1:0];
                    upd_next         = coord_count_reg < d_eff;
                    dim_next         = DIW'(coord_count_reg);
                    coord_count_next = cnt_inc;
                    mismatch_next    = cnt_inc != d_eff;
                    last_next        = s_tlast;
                    k_next           = k_eff;
                    iss_next         = '0;
                    state_next       = S_RUN;
                end
            end
            S_RUN: begin
                p1_v_next = 1'b1;
                if (KW'(iss_reg) == k_reg - KW'(1)) begin
                    state_next = S_DRAIN;
                end else begin
                    iss_next = iss_reg + CW'(1);
                end
            end
            S_DRAIN: begin
                if (!p1_v_reg) begin
                    state_next = last_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next     = 1'b1;
                    m_label_next     = LABEL_W'(best_c_reg);
                    m_dist_next      = best_sum_reg;
                    m_mis_next       = mismatch_reg;
                    sum_clr          = 1'b1;
                    coord_count_next = '0;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            coord_count_reg <= '0;
            iss_reg         <= '0;
            p1_v_reg        <= 1'b0;
            p2_v_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            coord_count_reg <= coord_count_next;
            iss_reg         <= iss_next;
            p1_v_reg        <= p1_v_next;
            p2_v_reg        <= p2_v_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p1_c_reg     <= p1_c_next;
        p2_c_reg     <= p2_c_next;
        x_reg        <= x_next;
        upd_reg      <= upd_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        dim_reg      <= dim_next;
        mismatch_reg <= mismatch_next;
        best_sum_reg <= best_sum_next;
        best_c_reg   <= best_c_next;
        m_label_reg  <= m_label_next;
        m_dist_reg   <= m_dist_next;
        m_mis_reg    <= m_mis_next;
    end

    // Center store
    ncas_center_store #(
        .ADDR_W (ST_AW),
        .DATA_W (STORE_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr ({CW'(in_csel), DIW'(in_dsel)}),
        .wr_data (in_coord[STORE_W-1:0]),
        .rd_addr ({iss_reg, dim_reg}),
        .rd_data (center_rd)
    );

    // Running sums
    ncas_sum_bank #(
        .DEPTH  (MAX_CENTERS),
        .ADDR_W (CW)
    ) u_sums (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (sum_clr),
        .wr_en   (p2_v_reg),
        .wr_addr (p2_c_reg),
        .wr_data (sum_new),
        .rd_addr (iss_reg),
        .rd_data (acc_rd)
    );

    // Shared squaring and accumulate unit
    assign sq_ctl.en     = p1_v_reg;
    assign sq_ctl.update = upd_reg;

    ncas_sq_unit #(
        .COORD_BITS (COORD_BITS),
        .STORE_W    (STORE_W)
    ) u_sq (
        .aclk       (aclk),
        .ctl        (sq_ctl),
        .point_raw  (x_reg),
        .center_raw (center_rd),
        .acc_in     (acc_rd),
        .sum_out    (sum_new)
    );

    // Ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - SUM_W - LABEL_W)'(0), m_dist_reg, m_label_reg};
    assign m_tuser  = m_mis_reg;

    // No center pass may still be in flight when a new item can enter
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!p1_v_reg && !p2_v_reg))
        else $error("center pass still in flight while ready");

    // Write-backs only touch active centers of the current item
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_v_reg |-> (KW'(p2_c_reg) < k_reg))
        else $error("sum write-back beyond active centers");

    // The coordinate count never passes its saturation point
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(coord_count_reg) <= MAX_DIMS + 1)
        else $error("coordinate count beyond saturation");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_tready) |=> (state_reg == S_DONE))
        else $error("result left while output still pending");

endmodule
